@@ hw/rtl/efba_pkg.sv @@
// Shared types and codes for the exact-fit bump allocator.
package efba_pkg;

  typedef enum logic [2:0] {
    ST_REUSED = 3'd0,
    ST_NEW    = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_FULL   = 3'd3,
    ST_FREED  = 3'd4,
    ST_REJECT = 3'd5,
    ST_NULL   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_HEAP_BASE   = 2'd0,
    CFG_HEAP_LENGTH = 2'd1,
    CFG_HEADER      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [7:0] HeaderReset = 8'd24;

  // search token walking down the cell chain
  typedef struct packed {
    logic        active;
    logic        is_free;
    logic [31:0] key;
    logic        hit;
    logic [31:0] addr;
  } tok_t;

  // append write broadcast to the chain
  typedef struct packed {
    logic        en;
    logic [31:0] size;
    logic [31:0] addr;
  } cell_wr_t;

endpackage

@@ hw/rtl/efba_if.sv @@
// Request and response channel interfaces.
interface efba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] request_size;
  logic [31:0] block_address;

  modport source (output valid, kind, request_size, block_address, input ready);
  modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface efba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;

  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

@@ hw/rtl/efba_cell.sv @@
// One table entry of the allocator chain: holds a block and checks the passing token.
module efba_cell import efba_pkg::*; #(
  parameter int unsigned MaxBlocks = 64,
  parameter int unsigned Idx       = 0,
  localparam int unsigned IdxW     = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1,
  localparam int unsigned CntW     = $clog2(MaxBlocks + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] cnt_i,
  input  cell_wr_t        wr_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  tok_t            tok_i,
  output tok_t            tok_o
);

  logic [31:0] size_q;
  logic [31:0] addr_q;
  logic        in_use_q;
  logic        in_use_d;
  logic        valid;
  logic        match;
  logic        wr_sel;
  tok_t        tok_q;
  tok_t        tok_d;

  assign valid  = CntW'(Idx) < cnt_i;
  assign wr_sel = wr_i.en && (wr_idx_i == IdxW'(Idx));

  always_comb begin
    match = 1'b0;
    if (tok_i.active && !tok_i.hit && valid) begin
      if (tok_i.is_free) begin
        match = in_use_q && (addr_q == tok_i.key);
      end else begin
        match = !in_use_q && (size_q == tok_i.key);
      end
    end
    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.addr = addr_q;
    end
    in_use_d = in_use_q;
    if (wr_sel) begin
      in_use_d = 1'b1;
    end else if (match) begin
      in_use_d = !tok_i.is_free;
    end
  end

  always_ff @(posedge clk_i) begin
    in_use_q <= in_use_d;
    if (wr_sel) begin
      size_q <= wr_i.size;
      addr_q <= wr_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hw/rtl/exact_fit_bump_allocator_top.sv @@
// An allocate or free passes from accept through the injection register, the cell chain, the
//   finish state and the output register; a free of zero skips straight to the finish state.
// Throughput: one item at a time; the search token walks the cell chain one entry per cycle.
// The next item is accepted as soon as the previous one has left for the output register.
// Reset: clears entry count, bump offset, registers (header to 24) and handshakes;
//   table contents stay undefined until written.
module exact_fit_bump_allocator_top import efba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  efba_req_if.sink    req,
  efba_rsp_if.source  rsp
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  state_e          state_q, state_d;
  logic [31:0]     base_q, len_q;
  logic [7:0]      hdr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     bump_q, bump_d;
  logic            kind_q, null_q, hit_q;
  logic [31:0]     size_q, hit_addr_q;
  tok_t            inj_q, inj_d;
  tok_t            chain [MAX_BLOCKS+1];
  cell_wr_t        wr;
  logic            out_v_q, out_v_d;
  logic [31:0]     out_addr_q, out_addr_d;
  status_e         out_st_q, out_st_d;
  logic            load;
  logic [33:0]     need;
  logic            nomem, full;
  logic [31:0]     new_addr;
  logic            accept;

  assign req.ready = state_q == S_IDLE;
  assign accept    = req.valid && req.ready;
  assign chain[0]  = inj_q;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    efba_cell #(
      .MaxBlocks (MAX_BLOCKS),
      .Idx       (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cnt_i    (cnt_q),
      .wr_i     (wr),
      .wr_idx_i (cnt_q[IdxW-1:0]),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1])
    );
  end

  assign need     = {2'b00, bump_q} + {26'd0, hdr_q} + {2'b00, size_q};
  assign nomem    = need >= {2'b00, len_q};
  assign full     = cnt_q == CntW'(MAX_BLOCKS);
  assign new_addr = base_q + bump_q + {24'd0, hdr_q};

  always_comb begin
    state_d    = state_q;
    inj_d      = '0;
    load       = 1'b0;
    wr         = '0;
    wr.size    = size_q;
    wr.addr    = new_addr;
    cnt_d      = cnt_q;
    bump_d     = bump_q;
    out_v_d    = out_v_q && !rsp.ready;
    out_addr_d = out_addr_q;
    out_st_d   = out_st_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_FREE && req.block_address == 32'd0) begin
            state_d = S_FINISH;
          end else begin
            inj_d.active  = 1'b1;
            inj_d.is_free = req.kind;
            inj_d.key     = (req.kind == KIND_FREE) ? req.block_address : req.request_size;
            state_d       = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chain[MAX_BLOCKS].active) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_v_q || rsp.ready) begin
          load       = 1'b1;
          out_v_d    = 1'b1;
          out_addr_d = 32'd0;
          state_d    = S_IDLE;
          if (null_q) begin
            out_st_d = ST_NULL;
          end else if (kind_q == KIND_FREE) begin
            out_st_d = hit_q ? ST_FREED : ST_REJECT;
          end else if (hit_q) begin
            out_st_d   = ST_REUSED;
            out_addr_d = hit_addr_q;
          end else if (full) begin
            out_st_d = ST_FULL;
          end else if (nomem) begin
            out_st_d = ST_NOMEM;
          end else begin
            out_st_d   = ST_NEW;
            out_addr_d = new_addr;
            wr.en      = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
            bump_d     = need[31:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      inj_q    <= '0;
      cnt_q    <= '0;
      bump_q   <= '0;
      out_v_q  <= 1'b0;
      base_q   <= '0;
      len_q    <= '0;
      hdr_q    <= HeaderReset;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      cnt_q   <= cnt_d;
      bump_q  <= bump_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEAP_BASE:   base_q <= cfg_data_i;
          CFG_HEAP_LENGTH: len_q  <= cfg_data_i;
          CFG_HEADER:      hdr_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
    if (accept) begin
      kind_q <= req.kind;
      size_q <= req.request_size;
      null_q <= (req.kind == KIND_FREE) && (req.block_address == 32'd0);
      hit_q  <= 1'b0;
    end else if (chain[MAX_BLOCKS].active) begin
      hit_q      <= chain[MAX_BLOCKS].hit;
      hit_addr_q <= chain[MAX_BLOCKS].addr;
    end
  end

  assign rsp.valid          = out_v_q;
  assign rsp.result_address = out_addr_q;
  assign rsp.status         = out_st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_BLOCKS))
    else $error("entry count beyond table depth");

  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_BLOCKS].active |-> state_q == S_SCAN)
    else $error("token left chain outside scan");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_st_d == ST_NEW) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("new block did not grow the table");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> (state_q == S_IDLE && !inj_q.active))
    else $error("item taken while busy");

endmodule
